>>> hw/rtl/srcv_pkg.sv
package srcv_pkg;

	// vector dimension; one lane per output component
	localparam int NUM_COMP = 3;

	// fixed field widths of the input item
	localparam int SYM_W  = 7;
	localparam int EIDX_W = 4;

	// config port: four 32-bit registers at byte addresses 0, 4, 8, 12
	localparam int ADDR_W = 4;

	// input item kind, carried on s_tuser
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_VECTOR = 1'b1;

	// register index, paddr[3:2]
	typedef enum logic [1:0] {
		REG_SYM_COUNT  = 2'd0,
		REG_TIME_REV   = 2'd1,
		REG_INDEX_BASE = 2'd2,
		REG_POL_COUNT  = 2'd3
	} reg_idx_t;

	// per-stage load enables shared by all lanes
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} lane_ctl_t;

endpackage

>>> hw/rtl/symmetry_rotate_complex_vector.sv
// Rotates complex 3-vectors by a stored real 3x3 symmetry matrix (transposed),
// conjugating unless the symmetry carries time reversal.
// Input stream (s_*): s_tuser = 0 is a load transfer that writes one matrix
// element at row sym_raw - index_base, position elem_index; s_tuser = 1 is a
// vector transfer that yields exactly one result. Loads yield nothing.
// Output stream (m_*): rotated, rounded and saturated vector; m_tuser flags
// that time reversal applied (no conjugation).
// Config: APB registers symmetry_count (0x0), time_reversal (0x4),
// index_base (0x8), pol_count (0xC); write them only while the block is idle.
// Throughput: one transfer per cycle while s_tready is high. Each of the three
// lanes owns the three table banks of its matrix column, so a whole column is
// read at once. Pipeline: table read at the transfer edge, then multiply, lane
// sum, round/saturate into the output register.
// Stall: a held result back-pressures the pipe stage by stage; s_tready only
// drops once every stage is full. Reset clears the pipeline and presets the
// registers; the matrix table is not cleared and must be loaded before use.
module symmetry_rotate_complex_vector import srcv_pkg::*; #(
	parameter int MAX_SYMMETRIES = 64,
	parameter int DATA_WIDTH = 24,
	parameter int COEF_WIDTH = 16,
	localparam int IN_TDATA_W =
		((SYM_W + EIDX_W + COEF_WIDTH + 2 * NUM_COMP * DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_TDATA_W = ((2 * NUM_COMP * DATA_WIDTH + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// sym_raw, elem_index, elem_value, in_re0, in_im0, in_re1, in_im1, in_re2, in_im2
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// kind
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_re0, out_im0, out_re1, out_im1, out_re2, out_im2
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// time_reversed
	output logic                   m_tuser
);

	localparam int ROW_W = (MAX_SYMMETRIES > 1) ? $clog2(MAX_SYMMETRIES) : 1;
	localparam int IDX_W = (ROW_W > SYM_W) ? ROW_W : SYM_W;
	localparam int SUM_W = COEF_WIDTH + DATA_WIDTH + 2;
	localparam int EIDX_LO = SYM_W;
	localparam int EVAL_LO = SYM_W + EIDX_W;
	localparam int VEC_LO = EVAL_LO + COEF_WIDTH;

	logic [SYM_W-1:0] sym_count_q;
	logic             time_rev_q;
	logic             index_base_q;
	logic [1:0]       pol_count_q;
	reg_idx_t         reg_idx;
	logic             cfg_wr;

	logic [SYM_W-1:0]             sym_raw;
	logic [EIDX_W-1:0]            elem_idx;
	logic signed [COEF_WIDTH-1:0] elem_val;
	logic signed [DATA_WIDTH-1:0] vec_re [NUM_COMP];
	logic signed [DATA_WIDTH-1:0] vec_im [NUM_COMP];
	logic [IDX_W-1:0]             row_ext;
	logic [ROW_W-1:0]             row;
	logic                         row_ok;
	logic                         trev_in;
	logic                         elem_ok;
	logic [1:0]                   wr_lane;
	logic [1:0]                   wr_bank;
	logic                         in_xfer;
	logic                         load_xfer;

	logic                         valid_s1, valid_s2, valid_s3;
	logic                         trev_s1, trev_s2, trev_s3;
	logic                         row_ok_s1;
	logic [1:0]                   pol_s1;
	logic signed [DATA_WIDTH-1:0] re_s1 [NUM_COMP];
	logic signed [DATA_WIDTH-1:0] im_s1 [NUM_COMP];
	logic                         ready1, ready2, ready3;
	logic                         out_ready;
	lane_ctl_t                    ctl;

	logic signed [SUM_W-1:0] sum_re_s3 [NUM_COMP];
	logic signed [SUM_W-1:0] sum_im_s3 [NUM_COMP];

	// ---------------- config port ----------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_count_q  <= SYM_W'(48);
			time_rev_q   <= 1'b0;
			index_base_q <= 1'b1;
			pol_count_q  <= 2'd3;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_SYM_COUNT:  sym_count_q  <= pwdata[SYM_W-1:0];
				REG_TIME_REV:   time_rev_q   <= pwdata[0];
				REG_INDEX_BASE: index_base_q <= pwdata[0];
				REG_POL_COUNT:  pol_count_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SYM_COUNT:  prdata = 32'(sym_count_q);
			REG_TIME_REV:   prdata = 32'(time_rev_q);
			REG_INDEX_BASE: prdata = 32'(index_base_q);
			REG_POL_COUNT:  prdata = 32'(pol_count_q);
			default:        prdata = '0;
		endcase
	end

	// ---------------- input decode ----------------
	assign sym_raw  = s_tdata[0 +: SYM_W];
	assign elem_idx = s_tdata[EIDX_LO +: EIDX_W];
	assign elem_val = s_tdata[EVAL_LO +: COEF_WIDTH];

	always_comb begin
		for (int j = 0; j < NUM_COMP; j++) begin
			vec_re[j] = s_tdata[VEC_LO + 2*j*DATA_WIDTH +: DATA_WIDTH];
			vec_im[j] = s_tdata[VEC_LO + (2*j+1)*DATA_WIDTH +: DATA_WIDTH];
		end
	end

	assign row_ext = IDX_W'(sym_raw) - IDX_W'(index_base_q);
	assign row     = row_ext[ROW_W-1:0];
	assign row_ok  = (sym_raw >= SYM_W'(index_base_q)) && (32'(row_ext) < MAX_SYMMETRIES);

	// sym_raw * (time_reversal + 1) >= symmetry_count
	assign trev_in = time_rev_q ? ({sym_raw, 1'b0} >= {1'b0, sym_count_q})
	                            : (sym_raw >= sym_count_q);

	// element position row*3+col: col picks the lane, row picks the bank
	always_comb begin
		elem_ok = 1'b1;
		wr_lane = 2'd0;
		wr_bank = 2'd0;
		case (elem_idx)
			4'd0: begin wr_lane = 2'd0; wr_bank = 2'd0; end
			4'd1: begin wr_lane = 2'd1; wr_bank = 2'd0; end
			4'd2: begin wr_lane = 2'd2; wr_bank = 2'd0; end
			4'd3: begin wr_lane = 2'd0; wr_bank = 2'd1; end
			4'd4: begin wr_lane = 2'd1; wr_bank = 2'd1; end
			4'd5: begin wr_lane = 2'd2; wr_bank = 2'd1; end
			4'd6: begin wr_lane = 2'd0; wr_bank = 2'd2; end
			4'd7: begin wr_lane = 2'd1; wr_bank = 2'd2; end
			4'd8: begin wr_lane = 2'd2; wr_bank = 2'd2; end
			default: elem_ok = 1'b0;
		endcase
	end

	// ---------------- pipeline control ----------------
	assign ready3 = !valid_s3 || out_ready;
	assign ready2 = !valid_s2 || ready3;
	assign ready1 = !valid_s1 || ready2;

	assign s_tready  = ready1;
	assign in_xfer   = s_tvalid && s_tready;
	assign load_xfer = in_xfer && (s_tuser == KIND_LOAD) && row_ok && elem_ok;

	assign ctl.en_s1 = ready1;
	assign ctl.en_s2 = ready2;
	assign ctl.en_s3 = ready3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready1)
				valid_s1 <= in_xfer && (s_tuser == KIND_VECTOR);
			if (ready2)
				valid_s2 <= valid_s1;
			if (ready3)
				valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready1) begin
			re_s1     <= vec_re;
			im_s1     <= vec_im;
			row_ok_s1 <= row_ok;
			pol_s1    <= pol_count_q;
			trev_s1   <= trev_in;
		end
		if (ready2)
			trev_s2 <= trev_s1;
		if (ready3)
			trev_s3 <= trev_s2;
	end

	// ---------------- lanes ----------------
	for (genvar i = 0; i < NUM_COMP; i++) begin : g_lane
		srcv_lane #(
			.LANE           (i),
			.MAX_SYMMETRIES (MAX_SYMMETRIES),
			.DATA_WIDTH     (DATA_WIDTH),
			.COEF_WIDTH     (COEF_WIDTH)
		) u_lane (
			.clk       (clk),
			.ctl       (ctl),
			.wr_en     (load_xfer && wr_lane == 2'(i)),
			.wr_bank   (wr_bank),
			.wr_row    (row),
			.wr_data   (elem_val),
			.rd_row    (row),
			.re_s1     (re_s1),
			.im_s1     (im_s1),
			.row_ok_s1 (row_ok_s1),
			.pol_s1    (pol_s1),
			.sum_re_s3 (sum_re_s3[i]),
			.sum_im_s3 (sum_im_s3[i])
		);
	end

	srcv_merge #(
		.DATA_WIDTH (DATA_WIDTH),
		.COEF_WIDTH (COEF_WIDTH)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.trev_s3   (trev_s3),
		.sum_re_s3 (sum_re_s3),
		.sum_im_s3 (sum_im_s3),
		.out_ready (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

>>> hw/rtl/srcv_lane.sv
module srcv_lane import srcv_pkg::*; #(
	parameter int LANE = 0,
	parameter int MAX_SYMMETRIES = 64,
	parameter int DATA_WIDTH = 24,
	parameter int COEF_WIDTH = 16,
	localparam int ROW_W = (MAX_SYMMETRIES > 1) ? $clog2(MAX_SYMMETRIES) : 1,
	localparam int PROD_W = COEF_WIDTH + DATA_WIDTH,
	localparam int SUM_W = PROD_W + 2
) (
	input  logic                         clk,
	input  lane_ctl_t                    ctl,
	input  logic                         wr_en,
	input  logic [1:0]                   wr_bank,
	input  logic [ROW_W-1:0]             wr_row,
	input  logic signed [COEF_WIDTH-1:0] wr_data,
	input  logic [ROW_W-1:0]             rd_row,
	input  logic signed [DATA_WIDTH-1:0] re_s1 [NUM_COMP],
	input  logic signed [DATA_WIDTH-1:0] im_s1 [NUM_COMP],
	input  logic                         row_ok_s1,
	input  logic [1:0]                   pol_s1,
	output logic signed [SUM_W-1:0]      sum_re_s3,
	output logic signed [SUM_W-1:0]      sum_im_s3
);

	logic signed [COEF_WIDTH-1:0] coef [NUM_COMP];
	logic signed [PROD_W-1:0]     prod_re_s2 [NUM_COMP];
	logic signed [PROD_W-1:0]     prod_im_s2 [NUM_COMP];
	logic [NUM_COMP-1:0]          use_j;

	// bank b holds column LANE of row b of every matrix: M[b][LANE]
	for (genvar b = 0; b < NUM_COMP; b++) begin : g_bank
		logic signed [COEF_WIDTH-1:0] bank_q [MAX_SYMMETRIES];
		logic signed [COEF_WIDTH-1:0] coef_s1;

		always_ff @(posedge clk) begin
			if (wr_en && wr_bank == 2'(b))
				bank_q[wr_row] <= wr_data;
			if (ctl.en_s1)
				coef_s1 <= bank_q[rd_row];
		end

		assign coef[b] = coef_s1;
	end

	always_comb begin
		for (int j = 0; j < NUM_COMP; j++)
			use_j[j] = row_ok_s1 && (2'(j) < pol_s1) && (2'(LANE) < pol_s1);
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			for (int j = 0; j < NUM_COMP; j++) begin
				if (use_j[j]) begin
					prod_re_s2[j] <= PROD_W'(coef[j]) * PROD_W'(re_s1[j]);
					prod_im_s2[j] <= PROD_W'(coef[j]) * PROD_W'(im_s1[j]);
				end else begin
					prod_re_s2[j] <= '0;
					prod_im_s2[j] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			sum_re_s3 <= SUM_W'(prod_re_s2[0]) + SUM_W'(prod_re_s2[1]) + SUM_W'(prod_re_s2[2]);
			sum_im_s3 <= SUM_W'(prod_im_s2[0]) + SUM_W'(prod_im_s2[1]) + SUM_W'(prod_im_s2[2]);
		end
	end

endmodule

>>> hw/rtl/srcv_merge.sv
module srcv_merge import srcv_pkg::*; #(
	parameter int DATA_WIDTH = 24,
	parameter int COEF_WIDTH = 16,
	localparam int SUM_W = COEF_WIDTH + DATA_WIDTH + 2,
	localparam int FRAC_W = COEF_WIDTH - 2,
	localparam int Q_W = SUM_W - FRAC_W,
	localparam int OUT_TDATA_W = ((2 * NUM_COMP * DATA_WIDTH + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_s3,
	input  logic                    trev_s3,
	input  logic signed [SUM_W-1:0] sum_re_s3 [NUM_COMP],
	input  logic signed [SUM_W-1:0] sum_im_s3 [NUM_COMP],
	output logic                    out_ready,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OUT_TDATA_W-1:0]  m_tdata,
	output logic                    m_tuser
);

	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_W - 1);
	localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
	localparam logic signed [Q_W-1:0] SAT_LO = -SAT_HI - Q_W'(1);

	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                   out_trev_q;
	logic [OUT_TDATA_W-1:0] packed_d;
	logic                   take;

	// round half up (floor after adding half an LSB), then clamp
	function automatic logic signed [DATA_WIDTH-1:0] round_sat(
		input logic signed [SUM_W-1:0] x
	);
		logic signed [SUM_W-1:0] r;
		logic signed [Q_W-1:0]   q;
		r = x + HALF;
		q = Q_W'(r >>> FRAC_W);
		if (q > SAT_HI)
			q = SAT_HI;
		else if (q < SAT_LO)
			q = SAT_LO;
		return q[DATA_WIDTH-1:0];
	endfunction

	always_comb begin
		packed_d = '0;
		for (int i = 0; i < NUM_COMP; i++) begin
			packed_d[2*i*DATA_WIDTH +: DATA_WIDTH] = round_sat(sum_re_s3[i]);
			// conjugate unless the symmetry is time reversed
			packed_d[(2*i+1)*DATA_WIDTH +: DATA_WIDTH] =
				round_sat(trev_s3 ? sum_im_s3[i] : -sum_im_s3[i]);
		end
	end

	assign out_ready = !out_valid_q || m_tready;
	assign take      = valid_s3 && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= packed_d;
			out_trev_q <= trev_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_trev_q;

endmodule

>>> hw/rtl/srcv_checker.sv
module srcv_checker import srcv_pkg::*; #(
	parameter int DATA_WIDTH = 24,
	localparam int OUT_TDATA_W = ((2 * NUM_COMP * DATA_WIDTH + 7) / 8) * 8
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   pready,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped before transfer");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("m_tdata/m_tuser changed while stalled");

	// input back-pressure only comes from a blocked output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("s_tready low without output stall");

	// reset held over a clock edge empties the output register
	a_reset_empty: assert property (@(posedge clk)
		!arst_n ##1 !arst_n |-> !m_tvalid)
		else $error("m_tvalid high during reset");

	// config port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind symmetry_rotate_complex_vector srcv_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_srcv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pready   (pready),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
